FILE: design/rsf_pkg.sv
`timescale 1ns / 1ps

package rsf_pkg;

  // Kernel selection codes
  localparam logic KERNEL_INT  = 1'b0;
  localparam logic KERNEL_FRAC = 1'b1;

  // Arithmetic constants
  localparam int unsigned PixMax     = 255;
  localparam int unsigned FracNumC   = 421;   // 10.525 * 40
  localparam int unsigned FracNumLR  = 170;   // 4.25 * 40
  localparam int unsigned FracDen    = 80;
  localparam int unsigned FracSatLim = (PixMax + 1) * FracDen;
  localparam int unsigned IntSatLim  = (PixMax + 1) * 2;
  // floor(t / 5) == (t * Recip5) >> 16 for t < 16384
  localparam int unsigned Recip5     = 13108;

  // Result queue depth
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Position within the current row
  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_ONE   = 2'd1,
    POS_TWO   = 2'd2
  } rsf_pos_e;

  // One result item
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_last;
    logic       frame_last;
    logic       run_last;
  } rsf_result_t;

endpackage

FILE: design/rsf_kernel.sv
`timescale 1ns / 1ps

module rsf_kernel import rsf_pkg::*; (
  input  logic       mode_i,
  input  logic [7:0] left_i,
  input  logic [7:0] center_i,
  input  logic [7:0] right_i,
  output logic [7:0] pixel_o
);

  logic signed [18:0] l19, c19, r19;
  logic signed [18:0] s_frac;
  logic signed [11:0] s_int;
  logic        [10:0] t_frac;
  logic        [24:0] q_prod;
  logic        [7:0]  pix_frac, pix_int;

  assign l19 = signed'({11'd0, left_i});
  assign c19 = signed'({11'd0, center_i});
  assign r19 = signed'({11'd0, right_i});

  // Fractional kernel: floor((421c - 170(l+r)) / 80), saturated
  assign s_frac = c19 * 19'(FracNumC) - (l19 + r19) * 19'(FracNumLR);
  // Below the saturation limit, s/80 = (s>>4)/5
  assign t_frac = s_frac[14:4];
  assign q_prod = {14'd0, t_frac} * 25'(Recip5);

  always_comb begin
    if (s_frac <= 19'sd0) begin
      pix_frac = 8'd0;
    end else if (s_frac >= 19'(FracSatLim)) begin
      pix_frac = 8'(PixMax);
    end else begin
      pix_frac = q_prod[23:16];
    end
  end

  // Integer kernel: (4c - l - r) >> 1, saturated
  assign s_int = 12'(c19 <<< 2) - 12'(l19) - 12'(r19);

  always_comb begin
    if (s_int <= 12'sd0) begin
      pix_int = 8'd0;
    end else if (s_int >= 12'(IntSatLim)) begin
      pix_int = 8'(PixMax);
    end else begin
      pix_int = s_int[8:1];
    end
  end

  assign pixel_o = (mode_i == KERNEL_FRAC) ? pix_frac : pix_int;

endmodule

FILE: design/row_sharpen_filter.sv
`timescale 1ns / 1ps
// Channel | Handshake                  | Payload
// in      | in_valid_i / in_stall_o    | pixel_in_i, row_end_i, frame_end_i
// out     | out_valid_o / out_stall_i  | pixel_out_o, row_last_o, frame_last_o, run_last_o
// cfg     | cfg_valid_i / cfg_ready_o  | cfg_kernel_mode_i
//
// One input item per clock unless stalled. Results are computed in the accepting cycle
// and land in a four-entry result queue; the first result is visible in the following
// cycle. An item makes zero, one or two results; input stalls while fewer than two queue
// entries are free. Reset clears the row position, held pixels, mode and queue.

module row_sharpen_filter import rsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pixel_in_i,
  input  logic       row_end_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pixel_out_o,
  output logic       row_last_o,
  output logic       frame_last_o,
  output logic       run_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_kernel_mode_i
);

  logic        mode_q;
  logic [7:0]  left_q, left_d;
  logic [7:0]  center_q, center_d;
  rsf_pos_e    pos_q, pos_d;

  rsf_result_t q_mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   count_q;

  logic        in_acc, out_acc, rend;
  logic [7:0]  sharp_pix;
  rsf_result_t res0, res1, wr_first;
  logic        res0_vld;
  logic [1:0]  n_wr;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (count_q > (QAw+1)'(QDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign rend        = row_end_i | frame_end_i;

  // Kernel mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= KERNEL_INT;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_kernel_mode_i;
    end
  end

  rsf_kernel u_kernel (
    .mode_i   (mode_q),
    .left_i   (left_q),
    .center_i (center_q),
    .right_i  (pixel_in_i),
    .pixel_o  (sharp_pix)
  );

  // Row tracking and result formation
  always_comb begin
    left_d   = left_q;
    center_d = center_q;
    pos_d    = pos_q;
    res0_vld = 1'b0;
    res0     = '{pixel: left_q, row_last: 1'b0, frame_last: 1'b0, run_last: ~rend};
    case (pos_q)
      POS_ONE: begin
        res0_vld = 1'b1;
        center_d = pixel_in_i;
        pos_d    = POS_TWO;
      end
      POS_TWO: begin
        res0_vld   = 1'b1;
        res0.pixel = sharp_pix;
        left_d     = center_q;
        center_d   = pixel_in_i;
      end
      default: begin
        left_d = pixel_in_i;
        pos_d  = POS_ONE;
      end
    endcase
    if (rend) begin
      pos_d = POS_START;
    end
    res1     = '{pixel: pixel_in_i, row_last: 1'b1, frame_last: frame_end_i, run_last: 1'b1};
    wr_first = res0_vld ? res0 : res1;
    n_wr     = {1'b0, res0_vld} + {1'b0, rend};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_START;
    end else if (in_acc) begin
      pos_q <= pos_d;
    end
  end

  // Held pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 8'd0;
      center_q <= 8'd0;
    end else if (in_acc) begin
      left_q   <= left_d;
      center_q <= center_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && n_wr != 2'd0) begin
      q_mem_q[wr_ptr_q] <= wr_first;
    end
    if (in_acc && n_wr == 2'd2) begin
      q_mem_q[wr_ptr_q + QAw'(1)] <= res1;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + QAw'(n_wr);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QAw'(1);
      end
      count_q <= count_q + (in_acc ? (QAw+1)'(n_wr) : '0) - (QAw+1)'(out_acc);
    end
  end

  assign pixel_out_o  = q_mem_q[rd_ptr_q].pixel;
  assign row_last_o   = q_mem_q[rd_ptr_q].row_last;
  assign frame_last_o = q_mem_q[rd_ptr_q].frame_last;
  assign run_last_o   = q_mem_q[rd_ptr_q].run_last;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rsf_pkg::*;

  // One pixel as offered on the input channel
  typedef struct {
    logic [7:0] pixel;
    logic       row_end;
    logic       frame_end;
  } pix_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] pixel_in_i;
  logic       row_end_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] pixel_out_o;
  logic       row_last_o;
  logic       frame_last_o;
  logic       run_last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_kernel_mode_i;

  pix_item_t   pixel_queue[$];
  rsf_result_t expected_pixels[$];

  // Shadow of the filter state
  logic       mode_shadow;
  logic [7:0] held_left;
  logic [7:0] held_center;
  rsf_pos_e   row_pos;

  int  err_count;
  int  gap_left;
  int  stall_left;
  bit  no_idle;

  row_sharpen_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_in_i       (pixel_in_i),
    .row_end_i        (row_end_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_out_o      (pixel_out_o),
    .row_last_o       (row_last_o),
    .frame_last_o     (frame_last_o),
    .run_last_o       (run_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_kernel_mode_i(cfg_kernel_mode_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Three-tap sharpen of one interior pixel, clamped to a byte
  function automatic logic [7:0] sharpen_pixel(input logic mode, input logic [7:0] l,
                                               input logic [7:0] c, input logic [7:0] r);
    int s;
    int q;
    if (mode == KERNEL_FRAC) begin
      s = int'(FracNumC) * int'(c) - int'(FracNumLR) * (int'(l) + int'(r));
      q = s / int'(FracDen);
    end else begin
      s = 4 * int'(c) - int'(l) - int'(r);
      q = s / 2;
    end
    if (s <= 0) return 8'd0;
    if (q > int'(PixMax)) return 8'(PixMax);
    return 8'(q);
  endfunction

  function automatic rsf_result_t make_result(input logic [7:0] pix, input logic rl,
                                              input logic fl, input logic last);
    rsf_result_t res;
    res.pixel      = pix;
    res.row_last   = rl;
    res.frame_last = fl;
    res.run_last   = last;
    return res;
  endfunction

  // Advance the shadow state by one accepted pixel and queue its results
  task automatic predict_pixel(input logic [7:0] pix, input logic rend_in, input logic fend);
    logic rend;
    rend = rend_in | fend;
    case (row_pos)
      POS_ONE: begin
        expected_pixels.push_back(make_result(held_left, 1'b0, 1'b0, !rend));
        held_center = pix;
        row_pos     = POS_TWO;
      end
      POS_TWO: begin
        expected_pixels.push_back(make_result(
          sharpen_pixel(mode_shadow, held_left, held_center, pix), 1'b0, 1'b0, !rend));
        held_left   = held_center;
        held_center = pix;
      end
      default: begin
        held_left = pix;
        row_pos   = POS_ONE;
      end
    endcase
    // row end flushes the last pixel unchanged
    if (rend) begin
      expected_pixels.push_back(make_result(pix, 1'b1, fend, 1'b1));
      row_pos = POS_START;
    end
  endtask

  // Input driver: holds a stalled item, idles in short bursts
  always @(posedge clk_i or negedge rst_ni) begin
    pix_item_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      pixel_in_i  <= 8'd0;
      row_end_i   <= 1'b0;
      frame_end_i <= 1'b0;
      gap_left    = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        predict_pixel(pixel_in_i, row_end_i, frame_end_i);
      end
      if (gap_left > 0) begin
        gap_left   = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pixel_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap_left   = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else begin
        nxt = pixel_queue.pop_front();
        in_valid_i  <= 1'b1;
        pixel_in_i  <= nxt.pixel;
        row_end_i   <= nxt.row_end;
        frame_end_i <= nxt.frame_end;
      end
    end
  end

  // Output monitor: checks each accepted result, stalls in short bursts
  always @(posedge clk_i or negedge rst_ni) begin
    rsf_result_t got;
    rsf_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = make_result(pixel_out_o, row_last_o, frame_last_o, run_last_o);
        if (expected_pixels.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result pixel=%0d row_last=%0b frame_last=%0b run_last=%0b",
                   $time, got.pixel, got.row_last, got.frame_last, got.run_last);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: mismatch expected pixel=%0d rl=%0b fl=%0b last=%0b,",
                     $time, want.pixel, want.row_last, want.frame_last, want.run_last,
                     " actual pixel=%0d rl=%0b fl=%0b last=%0b",
                     got.pixel, got.row_last, got.frame_last, got.run_last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left  = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        stall_left  = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_pixel(input logic [7:0] pix, input logic rend, input logic fend);
    pix_item_t it;
    it.pixel     = pix;
    it.row_end   = rend;
    it.frame_end = fend;
    pixel_queue.push_back(it);
  endtask

  // Mix of extremes, full-range values and smooth steps from the previous pixel
  function automatic logic [7:0] pick_pixel(input logic [7:0] prev);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 255;
      2, 3: v = $urandom_range(0, 255);
      default: v = int'(prev) + int'($urandom_range(0, 16)) - 8;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Random rows, mostly short, a few long; some end the frame
  task automatic queue_random_rows(input int n_items);
    int         count;
    int         len;
    int         kind;
    logic [7:0] pix;
    count = 0;
    pix   = 8'($urandom_range(0, 255));
    while (count < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
        6, 7, 8: len = $urandom_range(7, 20);
        default: len = $urandom_range(21, 60);
      endcase
      kind = $urandom_range(0, 9);
      for (int k = 0; k < len; k++) begin
        pix = pick_pixel(pix);
        if (k == len - 1) begin
          // frame end alone also closes the row
          push_pixel(pix, kind != 0, kind <= 1);
        end else begin
          push_pixel(pix, 1'b0, 1'b0);
        end
      end
      count += len;
    end
  endtask

  // Wait until every queued pixel is accepted and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    // first pixel of a row makes no result: give the pipe time to settle
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_kernel_mode(input logic mode);
    cfg_kernel_mode_i <= mode;
    cfg_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_shadow = mode;
    @(negedge clk_i);
  endtask

  task automatic queue_directed_edges();
    // single-pixel row and two-pixel row
    push_pixel(8'd255, 1'b1, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b1, 1'b0);
    // peak saturates high, trough clamps to zero
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b1, 1'b0);
    // flat row stays mid-range
    push_pixel(8'd128, 1'b0, 1'b0);
    push_pixel(8'd128, 1'b0, 1'b0);
    push_pixel(8'd128, 1'b1, 1'b0);
  endtask

  // Stimulus and phase control
  initial begin
    logic phase_modes[6];
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_kernel_mode_i = KERNEL_INT;
    in_valid_i        = 1'b0;
    pixel_in_i        = 8'd0;
    row_end_i         = 1'b0;
    frame_end_i       = 1'b0;
    out_stall_i       = 1'b0;
    err_count         = 0;
    no_idle           = 1'b0;
    mode_shadow       = KERNEL_INT;
    held_left         = 8'd0;
    held_center       = 8'd0;
    row_pos           = POS_START;
    phase_modes       = '{KERNEL_FRAC, KERNEL_INT, KERNEL_FRAC, KERNEL_INT,
                          KERNEL_FRAC, KERNEL_INT};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part in the reset mode, then the fractional kernel
    queue_directed_edges();
    push_pixel(8'd10, 1'b0, 1'b0);
    push_pixel(8'd20, 1'b0, 1'b0);
    push_pixel(8'd30, 1'b0, 1'b0);
    push_pixel(8'd40, 1'b1, 1'b1);
    push_pixel(8'd200, 1'b0, 1'b0);
    push_pixel(8'd100, 1'b0, 1'b0);
    push_pixel(8'd50, 1'b0, 1'b1);
    push_pixel(8'd7, 1'b0, 1'b1);
    wait_drained();
    write_kernel_mode(KERNEL_FRAC);
    queue_directed_edges();
    wait_drained();

    // random phases; the last runs with no idling on either side
    foreach (phase_modes[p]) begin
      write_kernel_mode(phase_modes[p]);
      if (p == 5) no_idle = 1'b1;
      queue_random_rows(300);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: row_sharpen_filter.f
design/rsf_pkg.sv
design/rsf_kernel.sv
design/row_sharpen_filter.sv
bench/tb_top.sv
